>>> rtl/sfp_pkg.sv
// Shared types, character codes and helpers for the sequence file parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfp_pkg;

  // Input formats
  localparam logic [1:0] FMT_FASTA   = 2'd0;
  localparam logic [1:0] FMT_GENBANK = 2'd1;
  localparam logic [1:0] FMT_EMBL    = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_TITLE      = 3'd0;
  localparam logic [2:0] KIND_SEQ        = 3'd1;
  localparam logic [2:0] KIND_ANNOT      = 3'd2;
  localparam logic [2:0] KIND_ANNOT_END  = 3'd3;
  localparam logic [2:0] KIND_RECORD_END = 3'd4;

  // Section phases
  localparam logic [1:0] PHASE_HEAD  = 2'd0;
  localparam logic [1:0] PHASE_ANNOT = 2'd1;
  localparam logic [1:0] PHASE_SEQ   = 2'd2;

  // Characters
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CASE_OFS = 8'd32;

  localparam logic [2:0] LEN_ORIGIN = 3'd6;
  localparam logic [2:0] LEN_SQ     = 3'd2;
  localparam logic [2:0] POS_MAX    = 3'd7;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0] phase;
    logic       at_line_start;
    logic [2:0] line_pos;
    logic       prefix_match;
    logic       prev_space;
    logic       header_active;
    logic       has_seq;
    logic       title_taken;
    logic       first_skipped;
  } parse_state_t;

  typedef struct packed {
    logic       last;
    logic [2:0] kind;
    logic [7:0] data;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } emit_set_t;

  function automatic parse_state_t parse_reset();
    parse_state_t s;
    s               = '0;
    s.at_line_start = 1'b1;
    s.prefix_match  = 1'b1;
    return s;
  endfunction

  // Append one result; the newest one carries the last flag.
  function automatic emit_set_t emit_add(emit_set_t s, logic [7:0] b, logic [2:0] k);
    emit_set_t o;
    o = s;
    if (s.n == 2'd0) begin
      o.r0 = '{last: 1'b1, kind: k, data: b};
      o.n  = 2'd1;
    end else if (s.n == 2'd1) begin
      o.r0.last = 1'b0;
      o.r1      = '{last: 1'b1, kind: k, data: b};
      o.n       = 2'd2;
    end
    return o;
  endfunction

  // Section marker letters: ORIGIN for GenBank, SQ for EMBL
  function automatic logic [7:0] marker_char(logic [1:0] fmt, logic [2:0] pos);
    logic [7:0] c;
    c = CH_NUL;
    if (fmt == FMT_GENBANK) begin
      unique case (pos)
        3'd0:    c = "O";
        3'd1:    c = "R";
        3'd2:    c = "I";
        3'd3:    c = "G";
        3'd4:    c = "I";
        3'd5:    c = "N";
        default: c = CH_NUL;
      endcase
    end else begin
      unique case (pos)
        3'd0:    c = "S";
        3'd1:    c = "Q";
        default: c = CH_NUL;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/sfp_step.sv
// Per-byte parse rule: next parse state and up to two results for one item.
// Depends on sfp_pkg.
`default_nettype none

module sfp_step import sfp_pkg::*; (
  input  parse_state_t st,
  input  logic [1:0]   fmt,
  input  logic [7:0]   b,
  input  logic         eoi,
  output parse_state_t st_nxt,
  output emit_set_t    em
);

  logic         lf;
  logic         is_lower;
  logic         is_upper;
  logic [2:0]   mark_len;
  logic [7:0]   mark_c;
  parse_state_t nx;
  emit_set_t    e;

  assign lf       = (b == CH_LF);
  assign is_lower = (b >= "a") && (b <= "z");
  assign is_upper = (b >= "A") && (b <= "Z");
  assign mark_len = (fmt == FMT_GENBANK) ? LEN_ORIGIN : LEN_SQ;
  assign mark_c   = marker_char(fmt, st.line_pos);

  always_comb begin
    nx = st;
    e  = '0;
    if (eoi) begin
      if (fmt == FMT_FASTA) begin
        e = emit_add(e, CH_NUL, KIND_RECORD_END);
      end else if (fmt == FMT_GENBANK || fmt == FMT_EMBL) begin
        if (fmt == FMT_GENBANK && st.phase == PHASE_HEAD && !st.title_taken
            && st.prev_space) begin
          e = emit_add(e, CH_SPACE, KIND_TITLE);
        end
        // open annotation line is closed before the record end
        if (st.phase == PHASE_ANNOT && !st.at_line_start) begin
          e = emit_add(e, CH_LF, KIND_ANNOT_END);
        end
        e = emit_add(e, CH_NUL, KIND_RECORD_END);
      end
      nx = parse_reset();
    end else begin
      if (fmt == FMT_FASTA) begin
        priority if (lf) begin
          nx.header_active = 1'b0;
        end else if (st.at_line_start && b == CH_GT) begin
          nx.header_active = 1'b1;
          if (st.has_seq) begin
            e          = emit_add(e, CH_NUL, KIND_RECORD_END);
            nx.has_seq = 1'b0;
          end
        end else if (st.header_active) begin
          e = emit_add(e, b, KIND_TITLE);
        end else begin
          e          = emit_add(e, b, KIND_SEQ);
          nx.has_seq = 1'b1;
        end
      end else if (fmt == FMT_GENBANK || fmt == FMT_EMBL) begin
        if (st.phase == PHASE_HEAD) begin
          if (fmt == FMT_GENBANK) begin
            priority if (st.title_taken) begin
              if (lf) nx.phase = PHASE_ANNOT;
              else    e = emit_add(e, b, KIND_TITLE);
            end else if (st.prev_space && b != CH_SPACE) begin
              // title opens at the space before the first non-space
              e              = emit_add(e, CH_SPACE, KIND_TITLE);
              nx.title_taken = 1'b1;
              if (lf) nx.phase = PHASE_ANNOT;
              else    e = emit_add(e, b, KIND_TITLE);
            end else begin
              nx.prev_space = (b == CH_SPACE);
            end
          end else begin
            priority if (!st.first_skipped) begin
              if (lf) nx.first_skipped = 1'b1;
            end else if (lf) begin
              nx.title_taken = 1'b1;
              nx.phase       = PHASE_ANNOT;
            end else begin
              e = emit_add(e, b, KIND_TITLE);
            end
          end
        end else if (st.phase == PHASE_ANNOT) begin
          if (lf) begin
            e = emit_add(e, CH_LF, KIND_ANNOT_END);
            if (st.prefix_match && st.line_pos >= mark_len) nx.phase = PHASE_SEQ;
          end else begin
            e = emit_add(e, b, KIND_ANNOT);
            if (st.prefix_match && st.line_pos < mark_len && b != mark_c) begin
              nx.prefix_match = 1'b0;
            end
            if (st.line_pos < POS_MAX) nx.line_pos = st.line_pos + 3'd1;
          end
        end else begin
          // sequence section: letters only, uppercased
          if (is_lower)      e = emit_add(e, b - CASE_OFS, KIND_SEQ);
          else if (is_upper) e = emit_add(e, b, KIND_SEQ);
        end
      end
      nx.at_line_start = lf;
      if (lf) begin
        nx.line_pos     = '0;
        nx.prefix_match = 1'b1;
        nx.prev_space   = 1'b0;
      end
    end
  end

  assign st_nxt = nx;
  assign em     = e;

endmodule

`default_nettype wire

>>> rtl/sequence_file_stream_parser.sv
// Sequence file stream parser: FASTA, GenBank and EMBL byte sorter.
// Results of an accepted item are registered in the queue; out_* shows its head.
// Throughput: one item per cycle while the result queue has two free slots;
// two-result items drain at one result per cycle while out_tready is high.
// Reset (rst_n low, synchronous): format FASTA, parse state cleared, queue empty.
// Depends on sfp_pkg and sfp_step.
`default_nettype none

module sequence_file_stream_parser import sfp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // config: format_select
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  // input items
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // end_of_input
  // result items
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic [2:0]      out_tuser,  // [2:0] out_kind
  output logic            out_tlast   // last_of_run
);

  logic [1:0]   fmt_r;
  parse_state_t st_r;
  parse_state_t st_nxt;
  emit_set_t    em;

  // result queue: four entries, up to two written and one read per cycle
  result_t           q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic [QPTR_W:0]   cnt_nxt;
  logic              in_acc;
  logic              out_acc;
  logic [1:0]        n_push;

  sfp_step u_step (
    .st     (st_r),
    .fmt    (fmt_r),
    .b      (in_tdata),
    .eoi    (in_tlast),
    .st_nxt (st_nxt),
    .em     (em)
  );

  // two free slots needed, independent of the output side
  assign in_tready = (cnt_r <= (QPTR_W+1)'(QDEPTH - 2));
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_acc   = out_tvalid && out_tready;
  assign n_push    = in_acc ? em.n : 2'd0;
  assign cnt_nxt   = cnt_r + (QPTR_W+1)'(n_push) - (QPTR_W+1)'(out_acc);

  // format register and parse state; a config write restarts parsing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_FASTA;
      st_r  <= parse_reset();
    end else if (cfg_we) begin
      fmt_r <= cfg_wdata;
      st_r  <= parse_reset();
    end else if (in_acc) begin
      st_r  <= st_nxt;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(n_push);
      if (out_acc) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r    <= cnt_nxt;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) q_mem[wr_ptr_r] <= em.r0;
    if (n_push == 2'd2) q_mem[wr_ptr_r + QPTR_W'(1)] <= em.r1;
  end

  assign out_tdata = q_mem[rd_ptr_r].data;
  assign out_tuser = q_mem[rd_ptr_r].kind;
  assign out_tlast = q_mem[rd_ptr_r].last;

endmodule

`default_nettype wire

>>> rtl/sfp_checker.sv
// Port-level checks for the sequence file parser, bound to the top level.
// Depends on sfp_pkg and sequence_file_stream_parser.
`default_nettype none

module sfp_checker import sfp_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic [2:0] out_tuser,
  input wire logic       out_tlast
);

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result item changed");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= KIND_RECORD_END)
    else $error("result kind out of range");

  // record end always closes the run of its item and carries a zero byte
  a_recend: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_RECORD_END |-> out_tlast && out_tdata == CH_NUL)
    else $error("malformed record end");

  a_annot_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ANNOT_END |-> out_tdata == CH_LF)
    else $error("annotation line end without line feed");

endmodule

bind sequence_file_stream_parser sfp_checker u_sfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

>>> verif/tb_sequence_file_stream_parser.sv
// Self-checking bench for sequence_file_stream_parser: FASTA, GenBank and EMBL byte sorting.
// A scoreboard class predicts every result from the accepted items; tasks send the items.
// Depends on sfp_pkg (formats, kinds, phases, characters) and the parser RTL.

module tb_sequence_file_stream_parser;
  import sfp_pkg::*;

  localparam logic [1:0] FMT_UNUSED = 2'd3;  // spare format code: bytes swallowed, no results
  localparam int SETTLE_CYCLES = 4;    // margin before a format write, for result-less items
  localparam int FLUSH_CYCLES  = 8;
  localparam int QUIET_LIMIT   = 5000; // well above the long receiver hold
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 430;

  typedef struct {
    logic [7:0] data;
    logic [2:0] kind;
    logic       last;
  } sorted_byte_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: its own copy of the parse state and of the format register.
  // ---------------------------------------------------------------------------
  class sorted_byte_board;
    logic [1:0] fmt;
    logic [1:0] phase;
    logic       at_line_start;
    logic [2:0] line_pos;
    logic       prefix_ok;
    logic       prev_space;
    logic       in_header;
    logic       has_seq;
    logic       title_done;
    logic       first_skipped;

    sorted_byte_t due_bytes[$];
    sorted_byte_t step_bytes[$];
    int errors;
    int items_noted;
    int results_checked;
    int record_ends;

    function new();
      errors          = 0;
      items_noted     = 0;
      results_checked = 0;
      record_ends     = 0;
      set_format(FMT_FASTA);
    endfunction

    function void clear_parse();
      phase         = PHASE_HEAD;
      at_line_start = 1'b1;
      line_pos      = '0;
      prefix_ok     = 1'b1;
      prev_space    = 1'b0;
      in_header     = 1'b0;
      has_seq       = 1'b0;
      title_done    = 1'b0;
      first_skipped = 1'b0;
    endfunction

    function void set_format(logic [1:0] f);
      fmt = f;
      clear_parse();
    endfunction

    function void add(logic [7:0] b, logic [2:0] k);
      sorted_byte_t sb;
      sb = '{b, k, 1'b0};
      step_bytes.insert(step_bytes.size(), sb);
    endfunction

    // Annotation line; a line that starts with the marker word opens the sequence part
    function void annotate(logic [7:0] b, logic lf, string word);
      if (lf) begin
        add(CH_LF, KIND_ANNOT_END);
        if (prefix_ok && line_pos >= word.len()) phase = PHASE_SEQ;
      end else begin
        add(b, KIND_ANNOT);
        if (prefix_ok && line_pos < word.len() && b != word[line_pos]) prefix_ok = 1'b0;
        if (line_pos < POS_MAX) line_pos++;
      end
    endfunction

    // Sequence part of the flat files: letters only, forced to upper case
    function void pass_letter(logic [7:0] b);
      if (b >= "a" && b <= "z") add(b - CASE_OFS, KIND_SEQ);
      else if (b >= "A" && b <= "Z") add(b, KIND_SEQ);
    endfunction

    function void note_input_byte(logic [7:0] b, logic eoi);
      logic lf;
      lf = (b == CH_LF);
      items_noted++;
      step_bytes.delete();
      if (eoi) begin
        if (fmt == FMT_FASTA) begin
          add(CH_NUL, KIND_RECORD_END);
        end else if (fmt == FMT_GENBANK || fmt == FMT_EMBL) begin
          if (fmt == FMT_GENBANK && phase == PHASE_HEAD && !title_done && prev_space)
            add(CH_SPACE, KIND_TITLE);
          if (phase == PHASE_ANNOT && !at_line_start) add(CH_LF, KIND_ANNOT_END);
          add(CH_NUL, KIND_RECORD_END);
        end
        clear_parse();
      end else begin
        case (fmt)
          FMT_FASTA: begin
            if (lf) begin
              in_header = 1'b0;
            end else if (at_line_start && b == CH_GT) begin
              in_header = 1'b1;
              if (has_seq) begin
                add(CH_NUL, KIND_RECORD_END);
                has_seq = 1'b0;
              end
            end else if (in_header) begin
              add(b, KIND_TITLE);
            end else begin
              add(b, KIND_SEQ);
              has_seq = 1'b1;
            end
          end
          FMT_GENBANK: begin
            if (phase == PHASE_HEAD) begin
              if (title_done) begin
                if (lf) phase = PHASE_ANNOT;
                else add(b, KIND_TITLE);
              end else if (prev_space && b != CH_SPACE) begin
                add(CH_SPACE, KIND_TITLE);
                title_done = 1'b1;
                if (lf) phase = PHASE_ANNOT;
                else add(b, KIND_TITLE);
              end else begin
                prev_space = (b == CH_SPACE);
              end
            end else if (phase == PHASE_ANNOT) begin
              annotate(b, lf, "ORIGIN");
            end else begin
              pass_letter(b);
            end
          end
          FMT_EMBL: begin
            if (phase == PHASE_HEAD) begin
              if (!first_skipped) begin
                if (lf) first_skipped = 1'b1;
              end else if (lf) begin
                title_done = 1'b1;
                phase      = PHASE_ANNOT;
              end else begin
                add(b, KIND_TITLE);
              end
            end else if (phase == PHASE_ANNOT) begin
              annotate(b, lf, "SQ");
            end else begin
              pass_letter(b);
            end
          end
          default: ;
        endcase
        at_line_start = lf;
        if (lf) begin
          line_pos   = '0;
          prefix_ok  = 1'b1;
          prev_space = 1'b0;
        end
      end
      if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].last = 1'b1;
      foreach (step_bytes[i]) due_bytes.insert(due_bytes.size(), step_bytes[i]);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_sorted_byte(logic [7:0] d, logic [2:0] k, logic l);
      sorted_byte_t want;
      results_checked++;
      if (due_bytes.size() == 0) begin
        report($sformatf("result with none pending: data=%02h kind=%0d last=%0b", d, k, l));
        return;
      end
      want = due_bytes.pop_front();
      if (want.kind == KIND_RECORD_END) record_ends++;
      if (d !== want.data || k !== want.kind || l !== want.last)
        report($sformatf("result %0d: expected data=%02h kind=%0d last=%0b, got %02h %0d %0b",
                         results_checked, want.data, want.kind, want.last, d, k, l));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       cfg_we     = 1'b0;
  logic [1:0] cfg_wdata  = '0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;   // [7:0] in_byte
  logic       in_tlast   = 1'b0; // end_of_input
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [7:0] out_byte
  logic [2:0] out_tuser;         // [2:0] out_kind
  logic       out_tlast;         // last_of_run

  always #5 clk = ~clk;

  sequence_file_stream_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  sorted_byte_board board;

  int send_idle_pct = 35;
  int recv_idle_pct = 48;
  bit hold_request  = 1'b0;  // asks the result sink for one long hold-off
  int files_sent    = 0;
  int writes_done   = 0;

  logic [7:0] file_bytes[$];  // the file being built, sent item by item

  // ---------------------------------------------------------------------------
  // File builders: well-formed files with random content, some broken ones
  // ---------------------------------------------------------------------------
  function automatic void put_byte(logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  // printable word, the odd space mixed in
  function automatic void put_word(int n);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) put_byte(CH_SPACE);
      else put_byte(8'($urandom_range(33, 126)));
    end
  endfunction

  // any byte value, line ends and spaces weighted up
  function automatic void put_noise(int n);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       put_byte(CH_LF);
        1:       put_byte(CH_SPACE);
        default: put_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  function automatic logic [7:0] seq_char();
    string      bases;
    logic [7:0] c;
    bases = "acgtnACGT";
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: c = bases[$urandom_range(0, 8)];
      6:       c = 8'("a" + $urandom_range(0, 25));
      7:       c = 8'("A" + $urandom_range(0, 25));
      8:       c = 8'("0" + $urandom_range(0, 9));
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // flat-file sequence lines: position number, then groups of bases
  function automatic void put_seq_lines(int n);
    repeat (n) begin
      put_text("   ");
      put_text($sformatf("%0d", $urandom_range(1, 999)));
      repeat ($urandom_range(1, 3)) begin
        put_byte(CH_SPACE);
        repeat ($urandom_range(1, 10)) put_byte(seq_char());
      end
      put_byte(CH_LF);
    end
  endfunction

  function automatic void compose_file(logic [1:0] f);
    file_bytes.delete();
    if (f == FMT_UNUSED || $urandom_range(0, 9) == 0) begin
      put_noise($urandom_range(1, 30));
      return;
    end
    case (f)
      FMT_FASTA: begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 7) != 0) begin
            put_byte(CH_GT);
            put_word($urandom_range(0, 10));
            put_byte(CH_LF);
          end
          repeat ($urandom_range(0, 3)) begin
            repeat ($urandom_range(0, 15)) put_byte(seq_char());
            if ($urandom_range(0, 9) == 0) put_byte(CH_GT); // sequence unless at line start
            put_byte(CH_LF);
          end
        end
        if ($urandom_range(0, 5) == 0) put_noise($urandom_range(1, 6));
      end
      FMT_GENBANK: begin
        // title search: no space, trailing space or a proper name
        put_text("LOCUS");
        repeat ($urandom_range(0, 3)) put_byte(CH_SPACE);
        put_word($urandom_range(0, 10));
        put_byte(CH_LF);
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 6))
            0: begin put_text("DEFINITION  "); put_word($urandom_range(0, 8)); end
            1: put_text("  ORGANISM");
            2: put_text("ORIGI");
            3: put_text("origin");
            4: ;
            5: put_noise($urandom_range(1, 6));
            default: put_text("ORIGINAL "); // prefix match still opens the sequence
          endcase
          put_byte(CH_LF);
        end
        if ($urandom_range(0, 6) == 0) begin
          // cut inside an annotation line
          put_text("COMMENT ");
          put_word($urandom_range(0, 3));
          return;
        end
        if ($urandom_range(0, 9) != 0) begin
          put_text("ORIGIN");
          if ($urandom_range(0, 1)) put_word($urandom_range(1, 4));
          put_byte(CH_LF);
          put_seq_lines($urandom_range(0, 3));
          put_text("//\n");
        end
      end
      default: begin  // EMBL
        if ($urandom_range(0, 7) != 0) begin
          put_text("ID   ");
          put_word($urandom_range(0, 8));
        end
        put_byte(CH_LF);
        put_text("DE   ");
        put_word($urandom_range(0, 10));
        put_byte(CH_LF);
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 5))
            0: put_text("XX");
            1: begin put_text("FT   "); put_word($urandom_range(0, 8)); end
            2: put_text("S");
            3: put_text("sq");
            4: put_text("SX");
            default: put_noise($urandom_range(1, 6));
          endcase
          put_byte(CH_LF);
        end
        if ($urandom_range(0, 6) == 0) begin
          put_text("CC   ");
          put_word($urandom_range(0, 3));
          return;
        end
        if ($urandom_range(0, 9) != 0) begin
          put_text("SQ   Sequence ");
          put_text($sformatf("%0d BP;\n", $urandom_range(1, 999)));
          put_seq_lines($urandom_range(0, 3));
          put_text("//\n");
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // One item; random gaps ahead of it, then hold until tready is seen at an edge.
  task automatic send_item(input logic [7:0] b, input logic eoi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eoi;
    do @(posedge clk); while (!in_tready);
    board.note_input_byte(b, eoi);
  endtask

  // Drops valid until all due results are back, so the next item starts a fresh step.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.due_bytes.size() != 0);
  endtask

  // The format register may only move while the parser is idle.
  task automatic write_format(input logic [1:0] f);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_format(f);
    writes_done++;
  endtask

  // Send the built file; pause_at >= 0 stops there until all results are back.
  task automatic send_queued(input bit with_eoi, input int pause_at);
    for (int i = 0; i < file_bytes.size(); i++) begin
      if (i == pause_at) wait_drained();
      send_item(file_bytes[i], 1'b0);
    end
    if (with_eoi) send_item(8'($urandom_range(0, 255)), 1'b1);
    file_bytes.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: checks each accepted result, stalls at random or on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        board.check_sorted_byte(out_tdata, out_tuser, out_tlast);
      if (hold_request) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: gives up after a long run of cycles in which no item moves.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int         ph;
    int         phase_items;
    int         fno;
    int         pick;
    logic [1:0] next_fmt;
    bit         with_eoi;
    bit         need_write;

    board      = new();
    need_write = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: FASTA straight after reset (format reset value). Header with a
    // top-bit byte, line end swallowed, record closed by the next header, NUL
    // title byte, record closed by end of input.
    file_bytes.delete();
    put_text(">");
    put_byte(8'hFF);
    put_text("\na\n>");
    put_byte(8'h00);
    send_queued(1'b1, -1);

    // GenBank: a trailing space met by end of input is the whole title; then a
    // title found mid-line, an annotation byte, and end inside the open line
    // (line end result ahead of record end).
    write_format(FMT_GENBANK);
    put_text("A ");
    send_queued(1'b1, -1);
    put_text(" B\nz");
    send_queued(1'b1, -1);

    // EMBL: empty first line skipped, title, SQ marker, lower-case base uppercased.
    write_format(FMT_EMBL);
    put_text("\nT\nSQ\na");
    send_queued(1'b1, -1);

    // Random part in three idling regimes: sender-heavy, receiver-heavy, none.
    write_format(FMT_FASTA);
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 48 : 0;
      recv_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 35 : 0;
      phase_items   = 0;
      fno           = 0;
      while (phase_items < PHASE_ITEMS) begin
        pick     = $urandom_range(0, 99);
        next_fmt = (fno == 1)  ? FMT_UNUSED :
                   (pick < 32) ? FMT_FASTA :
                   (pick < 64) ? FMT_GENBANK :
                   (pick < 95) ? FMT_EMBL : FMT_UNUSED;
        // a file left open without end of input is closed by a register write
        if (next_fmt != board.fmt || need_write || $urandom_range(0, 5) == 0)
          write_format(next_fmt);
        // first file of each regime runs into a long receiver hold-off
        if (fno == 0) hold_request = 1'b1;
        compose_file(next_fmt);
        with_eoi    = ($urandom_range(0, 7) != 0);
        need_write  = !with_eoi;
        phase_items += file_bytes.size() + int'(with_eoi);
        send_queued(with_eoi, (ph == 1 && fno == 0) ? file_bytes.size() / 2 : -1);
        fno++;
        files_sent++;
      end
    end

    wait_drained();
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (board.due_bytes.size() != 0) begin
      $display("%0d expected results never arrived", board.due_bytes.size());
      board.errors++;
    end

    $display("Run: %0d items in %0d random files plus directed cases, %0d format writes",
             board.items_noted, files_sent, writes_done);
    $display("     %0d results checked, %0d record ends, %0d mismatches",
             board.results_checked, board.record_ends, board.errors);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
